[hdl/lpbl_pkg.sv]
// Package for the lag-power bad-lag classifier: widths, mark codes,
// register indexes, the queue word type and the saturation helper.
// Depends on nothing; every other file uses it by scoped names.
package lpbl_pkg;

  // Set geometry. The lag counter wraps after MAX_LAGS lags.
  localparam int MAX_LAGS = 32;
  localparam int LAG_W    = (MAX_LAGS > 2) ? $clog2(MAX_LAGS) : 1;

  // Field widths of the channels.
  localparam int PWR_W      = 32;
  localparam int ISQ_W      = 16;
  localparam int IDX_W      = 5;
  localparam int MARK_W     = 3;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Width that holds 2*noise + power + base exactly.
  localparam int SUM_W = 35;

  // Product of a power and the Q0.16 factor.
  localparam int PROD_W = PWR_W + ISQ_W;

  // Queue between the classifier and the result stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // Power threshold 1.0 in Q23.8.
  localparam logic signed [PWR_W-1:0] ONE_Q8 = 32'sd256;

  // Reset value of the inverse square root register.
  localparam logic [ISQ_W-1:0] ISQ_RESET = 16'd46341;

  typedef enum logic [MARK_W-1:0] {
    MARK_GOOD        = 3'd0,
    MARK_PRIOR_BAD   = 3'd1,
    MARK_LOW_POWER   = 3'd2,
    MARK_AFTER_LOW   = 3'd3,
    MARK_FLUCTUATION = 3'd4,
    MARK_RESCINDED   = 3'd5
  } mark_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_LEVEL = 1'b0,
    REG_INV_SQRT    = 1'b1
  } cfg_reg_t;

  // One classified lag as it waits in the queue.
  typedef struct packed {
    logic             rescue;
    logic [IDX_W-1:0] fix_index;
    logic [IDX_W-1:0] lag_index;
    mark_t            mark;
    logic [CNT_W-1:0] good_count;
    logic             set_done;
  } qent_t;

  // Clamp a wide signed sum to the signed 32-bit range.
  function automatic logic signed [PWR_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-PWR_W+1){1'b0}}, {(PWR_W-1){1'b1}}};
    lo = {{(SUM_W-PWR_W+1){1'b1}}, {(PWR_W-1){1'b0}}};
    if (v > hi) begin
      sat32 = hi[PWR_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[PWR_W-1:0];
    end else begin
      sat32 = v[PWR_W-1:0];
    end
  endfunction

endpackage

[hdl/lpbl_if.sv]
// Channel interfaces of the classifier: input lags, results, configuration.
// Each carries valid, ready and the payload. Depends on lpbl_pkg.
interface lpbl_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [lpbl_pkg::PWR_W-1:0]       lag_power;
  logic signed [lpbl_pkg::PWR_W-1:0]       next_power;
  logic                                    prior_bad;
  logic                                    first_lag;
  logic                                    last_lag;

  modport source (output valid, lag_power, next_power, prior_bad, first_lag, last_lag,
                  input ready);
  modport sink (input valid, lag_power, next_power, prior_bad, first_lag, last_lag,
                output ready);
endinterface

interface lpbl_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpbl_pkg::IDX_W-1:0]  lag_index;
  logic [lpbl_pkg::MARK_W-1:0] mark_code;
  logic [lpbl_pkg::CNT_W-1:0]  good_count;
  logic                        end_of_run;
  logic                        set_done;

  modport source (output valid, lag_index, mark_code, good_count, end_of_run, set_done,
                  input ready);
  modport sink (input valid, lag_index, mark_code, good_count, end_of_run, set_done,
                output ready);
endinterface

interface lpbl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lpbl_pkg::CFG_IDX_W-1:0]  index;
  logic [lpbl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/lag_power_bad_lag_classifier.sv]
// Top level of the lag-power bad-lag classifier: front, queue, result stage.
// Depends on lpbl_pkg, lpbl_if, lpbl_front, lpbl_queue and lpbl_back.
//
//   channel   direction  words                    payload
//   lag_in    in         one per lag              lag_power next_power prior_bad first/last
//   res_out   out        one or two per lag       lag_index mark_code good_count flags
//   cfg       in         one per register write   index data
//
// One lag is accepted per cycle while the four-word queue has room; its
// result words pass through the queue into the output register.
// A rescued lag gives two words and holds the result stage until both are loaded.
// The cycle after lag zero settles the limit from the registered product.
// Reset (rst, synchronous) clears all set state and loads register defaults.
// Back pressure on res_out fills the queue, then drops lag_in.ready.
module lag_power_bad_lag_classifier (
  input  logic       clk,
  input  logic       rst,
  lpbl_in_if.sink    lag_in,
  lpbl_out_if.source res_out,
  lpbl_cfg_if.sink   cfg
);

  logic            q_push;
  logic            q_space;
  logic            q_pop;
  logic            q_head_valid;
  lpbl_pkg::qent_t q_entry;
  lpbl_pkg::qent_t q_head;

  lpbl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .lag_in  (lag_in),
    .cfg     (cfg),
    .q_space (q_space),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  lpbl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .space      (q_space),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  lpbl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .res_out    (res_out)
  );

  // A correction word is never the last word of its lag.
  a_fix_not_last: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.mark_code == lpbl_pkg::MARK_RESCINDED) |-> !res_out.end_of_run)
    else $error("correction word flagged as end of run");

  // The lag's own word follows its correction word at once.
  a_fix_then_main: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.ready && !res_out.end_of_run)
    |=> (res_out.valid && res_out.end_of_run))
    else $error("lag word did not follow its correction word");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !res_out.valid)
    else $error("result offered out of reset");

  // The queue only takes a word when it has room.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_space)
    else $error("queue written while full");

endmodule

[hdl/lpbl_front.sv]
// Front of the classifier: configuration registers, per-set state and the
// combinational marking of each lag. Depends on lpbl_pkg and lpbl_if.
module lpbl_front (
  input  logic            clk,
  input  logic            rst,
  lpbl_in_if.sink         lag_in,
  lpbl_cfg_if.sink        cfg,
  input  logic            q_space,
  output logic            q_push,
  output lpbl_pkg::qent_t q_entry
);

  // Configuration registers.
  logic signed [lpbl_pkg::PWR_W-1:0] noise_level;
  logic [lpbl_pkg::ISQ_W-1:0]        inv_sqrt;

  // Set state.
  logic signed [lpbl_pkg::PWR_W-1:0]   prod_hi;
  logic                                prod_rnd;
  logic signed [lpbl_pkg::SUM_W-2:0]   start_sum;
  logic                                pending;
  logic signed [lpbl_pkg::PWR_W-1:0]   fluct_limit;
  logic signed [lpbl_pkg::PWR_W-1:0]   prev_limit;
  logic                                low_seen_once;
  logic                                low_run_latched;
  logic [lpbl_pkg::LAG_W-1:0]          last_good_lag;
  logic [lpbl_pkg::LAG_W-1:0]          lag_counter;
  logic [lpbl_pkg::CNT_W-1:0]          good_counter;

  logic signed [lpbl_pkg::SUM_W-2:0]   start_sum_next;
  logic                                pending_next;
  logic signed [lpbl_pkg::PWR_W-1:0]   fluct_limit_next;
  logic signed [lpbl_pkg::PWR_W-1:0]   prev_limit_next;
  logic                                low_seen_once_next;
  logic                                low_run_latched_next;
  logic [lpbl_pkg::LAG_W-1:0]          last_good_lag_next;
  logic [lpbl_pkg::LAG_W-1:0]          lag_counter_next;
  logic [lpbl_pkg::CNT_W-1:0]          good_counter_next;

  // Working values of the current lag.
  logic                                acc;
  logic                                first;
  logic signed [lpbl_pkg::PWR_W-1:0]   w;
  logic signed [lpbl_pkg::PWR_W-1:0]   wn;
  logic signed [16:0]                  isq_s;
  logic signed [lpbl_pkg::PROD_W-1:0]  prod_full;
  logic signed [lpbl_pkg::SUM_W-1:0]   base_ext;
  logic signed [lpbl_pkg::SUM_W-1:0]   two_noise;
  logic signed [lpbl_pkg::SUM_W-1:0]   w_2n;
  logic signed [lpbl_pkg::SUM_W-1:0]   pend_sum;
  logic signed [lpbl_pkg::SUM_W-1:0]   upd_sum;
  logic signed [lpbl_pkg::PWR_W-1:0]   fl_cur;
  logic signed [lpbl_pkg::PWR_W-1:0]   first_limit;
  logic signed [lpbl_pkg::PWR_W-1:0]   fl_use;
  logic signed [lpbl_pkg::PWR_W-1:0]   pfl_use;
  logic                                lsee_use;
  logic                                lrun_use;
  logic [lpbl_pkg::LAG_W-1:0]          lgl_use;
  logic [lpbl_pkg::LAG_W-1:0]          k;
  logic [lpbl_pkg::LAG_W:0]            k_inc;
  logic [lpbl_pkg::CNT_W-1:0]          gc_use;
  lpbl_pkg::mark_t                     mark;
  logic                                rescue;
  logic                                limit_upd;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_level <= '0;
      inv_sqrt    <= lpbl_pkg::ISQ_RESET;
    end else if (cfg.valid) begin
      unique case (lpbl_pkg::cfg_reg_t'(cfg.index))
        lpbl_pkg::REG_NOISE_LEVEL: noise_level <= signed'(cfg.data);
        lpbl_pkg::REG_INV_SQRT:    inv_sqrt    <= cfg.data[lpbl_pkg::ISQ_W-1:0];
      endcase
    end
  end

  // Handshake toward the queue.
  assign acc           = lag_in.valid && q_space;
  assign lag_in.ready  = q_space;
  assign q_push        = acc;
  assign first         = lag_in.first_lag;
  assign w             = lag_in.lag_power;
  assign wn            = lag_in.next_power;

  // Base fluctuation product; rounding is folded into later adds as a carry.
  assign isq_s     = {1'b0, inv_sqrt};
  assign prod_full = w * isq_s;

  // Limit arithmetic at full width before saturation.
  assign base_ext  = {{(lpbl_pkg::SUM_W-lpbl_pkg::PWR_W){prod_hi[lpbl_pkg::PWR_W-1]}},
                      prod_hi};
  assign two_noise = {{(lpbl_pkg::SUM_W-lpbl_pkg::PWR_W-1){noise_level[lpbl_pkg::PWR_W-1]}},
                      noise_level, 1'b0};
  assign w_2n      = {{(lpbl_pkg::SUM_W-lpbl_pkg::PWR_W){w[lpbl_pkg::PWR_W-1]}}, w}
                     + two_noise;
  assign pend_sum  = {start_sum[lpbl_pkg::SUM_W-2], start_sum} + base_ext
                     + {{(lpbl_pkg::SUM_W-1){1'b0}}, prod_rnd};
  assign upd_sum   = w_2n + base_ext + {{(lpbl_pkg::SUM_W-1){1'b0}}, prod_rnd};

  // A limit left pending by lag zero is settled in the following cycle.
  assign fl_cur      = pending ? lpbl_pkg::sat32(pend_sum) : fluct_limit;
  assign first_limit = lpbl_pkg::sat32(w_2n);

  // Lag zero starts from fresh set state.
  assign fl_use   = first ? first_limit : fl_cur;
  assign pfl_use  = first ? first_limit : prev_limit;
  assign lsee_use = first ? 1'b0 : low_seen_once;
  assign lrun_use = first ? 1'b0 : low_run_latched;
  assign lgl_use  = first ? '0 : last_good_lag;
  assign k        = first ? '0 : lag_counter;
  assign gc_use   = first ? '0 : good_counter;
  assign k_inc    = {1'b0, k} + 1'b1;

  // Mark the lag; the rules apply in order.
  always_comb begin
    mark                 = lpbl_pkg::MARK_GOOD;
    rescue               = 1'b0;
    limit_upd            = 1'b0;
    low_run_latched_next = lrun_use;
    low_seen_once_next   = lsee_use;
    priority if (lag_in.prior_bad) begin
      mark = lpbl_pkg::MARK_PRIOR_BAD;
    end else if (lrun_use) begin
      mark = lpbl_pkg::MARK_AFTER_LOW;
    end else if (w <= lpbl_pkg::ONE_Q8) begin
      mark                 = lpbl_pkg::MARK_LOW_POWER;
      low_run_latched_next = lsee_use;
      low_seen_once_next   = 1'b1;
    end else begin
      low_seen_once_next = 1'b0;
      limit_upd          = 1'b1;
      if (w > fl_use) begin
        if (!lag_in.last_lag && (w < pfl_use) && (wn > fl_use) && (wn < w)) begin
          rescue = 1'b1;
        end else begin
          mark = lpbl_pkg::MARK_FLUCTUATION;
        end
      end
    end
  end

  // Counters and limits after this lag.
  always_comb begin
    start_sum_next     = start_sum;
    pending_next       = 1'b0;
    fluct_limit_next   = fl_cur;
    prev_limit_next    = prev_limit;
    last_good_lag_next = last_good_lag;
    lag_counter_next   = lag_counter;
    good_counter_next  = good_counter;
    if (acc) begin
      if (limit_upd) begin
        prev_limit_next = fl_use;
        if (first) begin
          pending_next     = 1'b1;
          start_sum_next   = w_2n[lpbl_pkg::SUM_W-2:0];
          fluct_limit_next = fl_use;
        end else begin
          fluct_limit_next = lpbl_pkg::sat32(upd_sum);
        end
      end else begin
        fluct_limit_next = fl_use;
        prev_limit_next  = pfl_use;
      end
      if (mark == lpbl_pkg::MARK_GOOD && !rescue && gc_use != '1) begin
        good_counter_next = gc_use + 1'b1;
      end else begin
        good_counter_next = gc_use;
      end
      last_good_lag_next = (mark == lpbl_pkg::MARK_GOOD) ? k : lgl_use;
      if (k_inc >= (lpbl_pkg::LAG_W+1)'(lpbl_pkg::MAX_LAGS)) begin
        lag_counter_next = '0;
      end else begin
        lag_counter_next = k_inc[lpbl_pkg::LAG_W-1:0];
      end
    end
  end

  // Set state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_hi         <= '0;
      prod_rnd        <= 1'b0;
      start_sum       <= '0;
      pending         <= 1'b0;
      fluct_limit     <= '0;
      prev_limit      <= '0;
      low_seen_once   <= 1'b0;
      low_run_latched <= 1'b0;
      last_good_lag   <= '0;
      lag_counter     <= '0;
      good_counter    <= '0;
    end else begin
      if (acc && first) begin
        prod_hi  <= prod_full[lpbl_pkg::PROD_W-1:lpbl_pkg::ISQ_W];
        prod_rnd <= prod_full[lpbl_pkg::ISQ_W-1];
      end
      start_sum   <= start_sum_next;
      pending     <= pending_next;
      fluct_limit <= fluct_limit_next;
      prev_limit  <= prev_limit_next;
      if (acc) begin
        low_seen_once   <= low_seen_once_next;
        low_run_latched <= low_run_latched_next;
      end
      last_good_lag <= last_good_lag_next;
      lag_counter   <= lag_counter_next;
      good_counter  <= good_counter_next;
    end
  end

  // Word handed to the queue.
  always_comb begin
    q_entry.rescue     = rescue;
    q_entry.fix_index  = lpbl_pkg::IDX_W'(lgl_use);
    q_entry.lag_index  = lpbl_pkg::IDX_W'(k);
    q_entry.mark       = mark;
    q_entry.good_count = good_counter_next;
    q_entry.set_done   = lag_in.last_lag;
  end

endmodule

[hdl/lpbl_queue.sv]
// Short queue of classified lags between the front and the result stage.
// Depends on lpbl_pkg for the word type and depth.
module lpbl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lpbl_pkg::qent_t push_entry,
  output logic            space,
  output logic            head_valid,
  output lpbl_pkg::qent_t head,
  input  logic            pop
);

  lpbl_pkg::qent_t              slots [lpbl_pkg::Q_DEPTH];
  logic [lpbl_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [lpbl_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [lpbl_pkg::Q_PTR_W:0]   count;

  assign space      = (count != (lpbl_pkg::Q_PTR_W+1)'(lpbl_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Storage for the queued words.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/lpbl_back.sv]
// Result stage: turns each queued lag into one or two result words and
// holds them in the output register. Depends on lpbl_pkg and lpbl_if.
module lpbl_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  lpbl_pkg::qent_t head,
  output logic            pop,
  lpbl_out_if.source      res_out
);

  logic out_valid;
  logic load;
  logic phase;
  logic phase_next;
  logic send_fix;

  assign res_out.valid = out_valid;
  assign load          = !out_valid || res_out.ready;

  // A rescued lag sends its correction word first, then its own word.
  assign send_fix = head.rescue && !phase;

  always_comb begin
    pop        = 1'b0;
    phase_next = phase;
    if (load && head_valid) begin
      if (send_fix) begin
        phase_next = 1'b1;
      end else begin
        pop        = 1'b1;
        phase_next = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= head_valid;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      res_out.good_count <= head.good_count;
      res_out.set_done   <= head.set_done;
      if (send_fix) begin
        res_out.lag_index  <= head.fix_index;
        res_out.mark_code  <= lpbl_pkg::MARK_RESCINDED;
        res_out.end_of_run <= 1'b0;
      end else begin
        res_out.lag_index  <= head.lag_index;
        res_out.mark_code  <= head.mark;
        res_out.end_of_run <= 1'b1;
      end
    end
  end

endmodule
